@@ src/ltss_pkg.sv @@
package ltss_pkg;

    localparam int NUM_MOTORS = 4;

    localparam logic [3:0] OP_TICK        = 4'd0;
    localparam logic [3:0] OP_FOCUS_MINUS = 4'd1;
    localparam logic [3:0] OP_FOCUS_PLUS  = 4'd2;
    localparam logic [3:0] OP_ZOOM_UP     = 4'd3;
    localparam logic [3:0] OP_ZOOM_DOWN   = 4'd4;
    localparam logic [3:0] OP_PAN_LEFT    = 4'd5;
    localparam logic [3:0] OP_PAN_RIGHT   = 4'd6;
    localparam logic [3:0] OP_TILT_UP     = 4'd7;
    localparam logic [3:0] OP_TILT_DOWN   = 4'd8;
    localparam logic [3:0] OP_STANDBY     = 4'd9;

    localparam logic [1:0] MTR_FOCUS = 2'd0;
    localparam logic [1:0] MTR_ZOOM  = 2'd1;
    localparam logic [1:0] MTR_PAN   = 2'd2;
    localparam logic [1:0] MTR_TILT  = 2'd3;

    localparam logic [1:0] LDIR_NONE  = 2'd0;
    localparam logic [1:0] LDIR_MINUS = 2'd1;
    localparam logic [1:0] LDIR_PLUS  = 2'd2;

    typedef logic [3:0] t_coils;
    typedef logic [1:0] t_phase;

    typedef struct packed {
        t_coils     focus_coils;
        t_coils     zoom_coils;
        t_coils     pan_coils;
        t_coils     tilt_coils;
        logic [3:0] running_flags;
    } t_result;

    function automatic t_coils lens_coils(input t_phase ph);
        t_coils c;
        case (ph)
            2'd0: c = 4'b1001;
            2'd1: c = 4'b1010;
            2'd2: c = 4'b0110;
            default: c = 4'b0101;
        endcase
        return c;
    endfunction

    function automatic t_coils pt_coils(input t_phase ph);
        t_coils c;
        case (ph)
            2'd0: c = 4'b1001;
            2'd1: c = 4'b1100;
            2'd2: c = 4'b0110;
            default: c = 4'b0011;
        endcase
        return c;
    endfunction

endpackage

@@ src/lens_and_pan_tilt_stepper_sequencer_core.sv @@
// four-motor stepper sequencer: focus, zoom, pan and tilt coil drive
// input channel: i_valid, i_opcode, i_step_count; the block drives o_stall
// opcodes: tick, eight move commands (motor and direction), standby
// a move loads direction and step count; a tick steps focus else zoom,
// and pan else tilt, latching the coil pattern of the current phase
// output channel: o_valid with the four coil patterns and running flags,
// the state after the transfer; the receiver drives i_stall
// results are registered: in the result register, or in the skid register while that one is stalled
// throughput: one item per cycle while o_stall is low, set by the single state update stage
// a two-entry output buffer (result register plus skid register) lets an
// item be taken while a result waits; o_stall rises only when both hold
// results, i.e. when an item arrives while the result register is stalled
// reset: all motors stopped, phases zero, coils off, no result pending
module lens_and_pan_tilt_stepper_sequencer_core #(
    parameter int STEP_COUNT_WIDTH = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [3:0]                  i_opcode,
    input  logic [STEP_COUNT_WIDTH-1:0] i_step_count,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [3:0]                  o_focus_coils,
    output logic [3:0]                  o_zoom_coils,
    output logic [3:0]                  o_pan_coils,
    output logic [3:0]                  o_tilt_coils,
    output logic [3:0]                  o_running_flags
);
    import ltss_pkg::*;

    localparam int CW = STEP_COUNT_WIDTH + 1;

    t_phase          r_phase [NUM_MOTORS];
    t_phase          n_phase [NUM_MOTORS];
    logic            r_dir   [NUM_MOTORS];
    logic            n_dir   [NUM_MOTORS];
    logic            r_run   [NUM_MOTORS];
    logic            n_run   [NUM_MOTORS];
    logic [CW-1:0]   r_steps [NUM_MOTORS];
    logic [CW-1:0]   n_steps [NUM_MOTORS];
    t_coils          r_coils [NUM_MOTORS];
    t_coils          n_coils [NUM_MOTORS];
    t_phase          r_llp   [2];
    t_phase          n_llp   [2];
    logic [1:0]      r_ldir  [2];
    logic [1:0]      n_ldir  [2];
    logic            r_stby  [2];
    logic            n_stby  [2];

    t_result         r_out;
    t_result         r_skid;
    logic            r_out_vld;
    logic            r_skid_vld;
    t_result         w_res;
    logic            w_accept;

    logic            v_step [NUM_MOTORS];
    logic [3:0]      v_rel;
    logic [1:0]      v_mtr;
    logic            v_anti;
    logic [CW-1:0]   v_cnt;
    t_phase          v_llp;

    assign w_accept = i_valid && !r_skid_vld;
    assign o_stall  = r_skid_vld;

    always_comb begin
        n_phase = r_phase;
        n_dir   = r_dir;
        n_run   = r_run;
        n_steps = r_steps;
        n_coils = r_coils;
        n_llp   = r_llp;
        n_ldir  = r_ldir;
        n_stby  = r_stby;
        v_rel   = i_opcode - OP_FOCUS_MINUS;
        v_mtr   = v_rel[2:1];
        v_anti  = !v_rel[0];
        v_cnt   = {1'b0, i_step_count};
        v_llp   = r_llp[v_mtr[0]];
        v_step[MTR_FOCUS] = r_run[MTR_FOCUS];
        v_step[MTR_ZOOM]  = !r_run[MTR_FOCUS] && r_run[MTR_ZOOM];
        v_step[MTR_PAN]   = r_run[MTR_PAN];
        v_step[MTR_TILT]  = !r_run[MTR_PAN] && r_run[MTR_TILT];
        unique case (i_opcode) inside
            OP_TICK: begin
                for (int m = 0; m < NUM_MOTORS; m++) begin
                    if (v_step[m]) begin
                        if (m < 2) begin
                            n_coils[m] = lens_coils(r_phase[m]);
                            n_llp[m % 2] = r_phase[m];
                        end else begin
                            n_coils[m] = pt_coils(r_phase[m]);
                        end
                        n_phase[m] = r_dir[m] ? r_phase[m] + 2'd1 : r_phase[m] - 2'd1;
                        if (r_steps[m] <= CW'(1)) begin
                            n_run[m]   = 1'b0;
                            n_dir[m]   = 1'b0;
                            n_steps[m] = '0;
                        end else begin
                            n_steps[m] = r_steps[m] - CW'(1);
                        end
                    end
                end
            end
            OP_FOCUS_MINUS, OP_FOCUS_PLUS, OP_ZOOM_UP, OP_ZOOM_DOWN: begin
                if (r_stby[v_mtr[0]]) begin
                    n_stby[v_mtr[0]] = 1'b0;
                    v_llp = v_anti ? v_llp - 2'd1 : v_llp + 2'd1;
                    v_cnt = v_cnt + CW'(1);
                end
                n_llp[v_mtr[0]] = v_llp;
                if (r_ldir[v_mtr[0]] == LDIR_NONE) begin
                    n_phase[v_mtr] = '0;
                end else begin
                    n_phase[v_mtr] = v_anti ? v_llp + 2'd1 : v_llp - 2'd1;
                end
                n_ldir[v_mtr[0]] = v_anti ? LDIR_MINUS : LDIR_PLUS;
                n_dir[v_mtr]     = v_anti;
                n_steps[v_mtr]   = v_cnt;
                n_run[v_mtr]     = 1'b1;
            end
            OP_PAN_LEFT, OP_PAN_RIGHT, OP_TILT_UP, OP_TILT_DOWN: begin
                n_dir[v_mtr]   = v_anti;
                n_phase[v_mtr] = '0;
                n_steps[v_mtr] = v_cnt;
                n_run[v_mtr]   = 1'b1;
            end
            OP_STANDBY: begin
                n_stby[0]          = 1'b1;
                n_stby[1]          = 1'b1;
                n_coils[MTR_FOCUS] = '0;
                n_coils[MTR_ZOOM]  = '0;
            end
            default: begin
            end
        endcase
        w_res.focus_coils   = n_coils[MTR_FOCUS];
        w_res.zoom_coils    = n_coils[MTR_ZOOM];
        w_res.pan_coils     = n_coils[MTR_PAN];
        w_res.tilt_coils    = n_coils[MTR_TILT];
        w_res.running_flags = {n_run[MTR_TILT], n_run[MTR_PAN],
                               n_run[MTR_ZOOM], n_run[MTR_FOCUS]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int m = 0; m < NUM_MOTORS; m++) begin
                r_phase[m] <= '0;
                r_dir[m]   <= 1'b0;
                r_run[m]   <= 1'b0;
                r_steps[m] <= '0;
                r_coils[m] <= '0;
            end
            for (int k = 0; k < 2; k++) begin
                r_llp[k]  <= '0;
                r_ldir[k] <= LDIR_NONE;
                r_stby[k] <= 1'b0;
            end
        end else if (w_accept) begin
            r_phase <= n_phase;
            r_dir   <= n_dir;
            r_run   <= n_run;
            r_steps <= n_steps;
            r_coils <= n_coils;
            r_llp   <= n_llp;
            r_ldir  <= n_ldir;
            r_stby  <= n_stby;
        end
    end

    // result register with skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (!r_out_vld || !i_stall) begin
            if (r_skid_vld) begin
                r_out      <= r_skid;
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end else if (w_accept) begin
                r_out     <= w_res;
                r_out_vld <= 1'b1;
            end else begin
                r_out_vld <= 1'b0;
            end
        end else if (w_accept) begin
            r_skid     <= w_res;
            r_skid_vld <= 1'b1;
        end
    end

    assign o_valid         = r_out_vld;
    assign o_focus_coils   = r_out.focus_coils;
    assign o_zoom_coils    = r_out.zoom_coils;
    assign o_pan_coils     = r_out.pan_coils;
    assign o_tilt_coils    = r_out.tilt_coils;
    assign o_running_flags = r_out.running_flags;

endmodule

@@ bench/ltss_drive_checker.sv @@
module ltss_drive_checker #(
    parameter int STEP_W = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    input  logic               i_cmd_stall,
    input  logic [3:0]         i_opcode,
    input  logic [STEP_W-1:0]  i_step_count,
    input  logic               i_drv_valid,
    input  logic               i_drv_stall,
    input  ltss_pkg::t_result  i_drive,
    output int                 o_mismatches,
    output int                 o_outstanding,
    output int                 o_compared
);
    timeunit 1ns;
    timeprecision 1ps;
    import ltss_pkg::*;

    // coil patterns by phase, phase 0 in the low nibble
    localparam logic [15:0] LENS_SEQ = 16'h56A9;
    localparam logic [15:0] PT_SEQ   = 16'h36C9;

    t_phase          phase_r     [NUM_MOTORS];
    logic            anti_r      [NUM_MOTORS];
    logic            running_r   [NUM_MOTORS];
    logic [STEP_W:0] left_r      [NUM_MOTORS];
    t_coils          coils_r     [NUM_MOTORS];
    t_phase          lens_last_r [2];
    logic [1:0]      lens_dir_r  [2];
    logic            lens_sb_r   [2];
    t_result         drive_q     [$];
    t_result         want;
    int              shown;

    function automatic void clear_sequencer();
        for (int k = 0; k < NUM_MOTORS; k++) begin
            phase_r[k]   = '0;
            anti_r[k]    = 1'b0;
            running_r[k] = 1'b0;
            left_r[k]    = '0;
            coils_r[k]   = '0;
        end
        for (int k = 0; k < 2; k++) begin
            lens_last_r[k] = '0;
            lens_dir_r[k]  = LDIR_NONE;
            lens_sb_r[k]   = 1'b0;
        end
    endfunction

    function automatic void step_motor(input logic [1:0] m);
        t_phase ph;
        ph = phase_r[m];
        if (m == MTR_FOCUS || m == MTR_ZOOM) begin
            coils_r[m] = LENS_SEQ[4*ph +: 4];
            lens_last_r[m[0]] = ph;
        end else begin
            coils_r[m] = PT_SEQ[4*ph +: 4];
        end
        phase_r[m] = anti_r[m] ? ph + 2'd1 : ph - 2'd1;
        if (left_r[m] <= 1) begin
            running_r[m] = 1'b0;
            anti_r[m]    = 1'b0;
            left_r[m]    = '0;
        end else begin
            left_r[m] = left_r[m] - 1'b1;
        end
    endfunction

    function automatic void move_lens(input logic [1:0] m, input logic minus,
                                      input logic [STEP_W-1:0] cnt);
        logic [STEP_W:0] n;
        n = {1'b0, cnt};
        // leaving standby: back up one phase and add a catch-up step
        if (lens_sb_r[m[0]]) begin
            lens_sb_r[m[0]] = 1'b0;
            lens_last_r[m[0]] = minus ? lens_last_r[m[0]] - 2'd1 : lens_last_r[m[0]] + 2'd1;
            n = n + 1'b1;
        end
        if (lens_dir_r[m[0]] == LDIR_NONE) begin
            phase_r[m] = '0;
        end else begin
            phase_r[m] = minus ? lens_last_r[m[0]] + 2'd1 : lens_last_r[m[0]] - 2'd1;
        end
        lens_dir_r[m[0]] = minus ? LDIR_MINUS : LDIR_PLUS;
        anti_r[m]    = minus;
        left_r[m]    = n;
        running_r[m] = 1'b1;
    endfunction

    function automatic void move_pan_tilt(input logic [1:0] m, input logic anti,
                                          input logic [STEP_W-1:0] cnt);
        anti_r[m]    = anti;
        phase_r[m]   = '0;
        left_r[m]    = {1'b0, cnt};
        running_r[m] = 1'b1;
    endfunction

    function automatic t_result advance_sequencer(input logic [3:0] op,
                                                  input logic [STEP_W-1:0] cnt);
        t_result r;
        case (op)
            OP_TICK: begin
                if (running_r[MTR_FOCUS]) begin
                    step_motor(MTR_FOCUS);
                end else if (running_r[MTR_ZOOM]) begin
                    step_motor(MTR_ZOOM);
                end
                if (running_r[MTR_PAN]) begin
                    step_motor(MTR_PAN);
                end else if (running_r[MTR_TILT]) begin
                    step_motor(MTR_TILT);
                end
            end
            OP_FOCUS_MINUS: move_lens(MTR_FOCUS, 1'b1, cnt);
            OP_FOCUS_PLUS:  move_lens(MTR_FOCUS, 1'b0, cnt);
            OP_ZOOM_UP:     move_lens(MTR_ZOOM, 1'b1, cnt);
            OP_ZOOM_DOWN:   move_lens(MTR_ZOOM, 1'b0, cnt);
            OP_PAN_LEFT:    move_pan_tilt(MTR_PAN, 1'b1, cnt);
            OP_PAN_RIGHT:   move_pan_tilt(MTR_PAN, 1'b0, cnt);
            OP_TILT_UP:     move_pan_tilt(MTR_TILT, 1'b1, cnt);
            OP_TILT_DOWN:   move_pan_tilt(MTR_TILT, 1'b0, cnt);
            OP_STANDBY: begin
                lens_sb_r[MTR_FOCUS] = 1'b1;
                lens_sb_r[MTR_ZOOM]  = 1'b1;
                coils_r[MTR_FOCUS]   = '0;
                coils_r[MTR_ZOOM]    = '0;
            end
            default: ;
        endcase
        r.focus_coils   = coils_r[MTR_FOCUS];
        r.zoom_coils    = coils_r[MTR_ZOOM];
        r.pan_coils     = coils_r[MTR_PAN];
        r.tilt_coils    = coils_r[MTR_TILT];
        r.running_flags = {running_r[MTR_TILT], running_r[MTR_PAN],
                           running_r[MTR_ZOOM], running_r[MTR_FOCUS]};
        return r;
    endfunction

    function automatic void check_field(input string name, input t_coils exp_v,
                                        input t_coils got_v);
        if (exp_v !== got_v) begin
            o_mismatches++;
            if (shown < 10) begin
                shown++;
                $display("%0t ns %s: expected %b, got %b", $time, name, exp_v, got_v);
            end
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_sequencer();
            drive_q.delete();
            o_mismatches = 0;
            o_compared   = 0;
            shown        = 0;
        end else begin
            if (i_drv_valid && !i_drv_stall) begin
                if (drive_q.size() == 0) begin
                    o_mismatches++;
                    if (shown < 10) begin
                        shown++;
                        $display("%0t ns unexpected coil drive transfer %h", $time, i_drive);
                    end
                end else begin
                    want = drive_q.pop_front();
                    o_compared++;
                    check_field("focus_coils", want.focus_coils, i_drive.focus_coils);
                    check_field("zoom_coils", want.zoom_coils, i_drive.zoom_coils);
                    check_field("pan_coils", want.pan_coils, i_drive.pan_coils);
                    check_field("tilt_coils", want.tilt_coils, i_drive.tilt_coils);
                    check_field("running_flags", want.running_flags, i_drive.running_flags);
                end
            end
            if (i_cmd_valid && !i_cmd_stall) begin
                drive_q.push_back(advance_sequencer(i_opcode, i_step_count));
            end
        end
        o_outstanding = drive_q.size();
    end

endmodule

@@ bench/testbench.sv @@
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import ltss_pkg::*;

    localparam int          SCW          = 16;
    localparam int          RANDOM_ITEMS = 1800;
    localparam int          CYCLE_LIMIT  = 200000;
    localparam logic [3:0]  OP_UNUSED_LO = OP_STANDBY + 4'd1;
    localparam logic [3:0]  OP_UNUSED_HI = 4'hF;

    logic           i_clk        = 1'b0;
    logic           i_rst_n      = 1'b0;
    logic           i_valid      = 1'b0;
    logic [3:0]     i_opcode     = OP_TICK;
    logic [SCW-1:0] i_step_count = '0;
    logic           i_stall      = 1'b0;
    logic           o_stall;
    logic           o_valid;
    logic [3:0]     o_focus_coils;
    logic [3:0]     o_zoom_coils;
    logic [3:0]     o_pan_coils;
    logic [3:0]     o_tilt_coils;
    logic [3:0]     o_running_flags;
    t_result        drive_seen;

    int             idle_pct  = 31;
    int             stall_pct = 31;
    int             cycles    = 0;
    int             sent      = 0;
    int             mismatches;
    int             outstanding;
    int             compared;
    int unsigned    pick;
    logic [3:0]     r_op;
    logic [SCW-1:0] r_cnt;

    always #10 i_clk = ~i_clk;

    lens_and_pan_tilt_stepper_sequencer_core #(
        .STEP_COUNT_WIDTH(SCW)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_opcode       (i_opcode),
        .i_step_count   (i_step_count),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_focus_coils  (o_focus_coils),
        .o_zoom_coils   (o_zoom_coils),
        .o_pan_coils    (o_pan_coils),
        .o_tilt_coils   (o_tilt_coils),
        .o_running_flags(o_running_flags)
    );

    assign drive_seen = {o_focus_coils, o_zoom_coils, o_pan_coils, o_tilt_coils,
                         o_running_flags};

    ltss_drive_checker #(
        .STEP_W(SCW)
    ) checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (i_valid),
        .i_cmd_stall  (o_stall),
        .i_opcode     (i_opcode),
        .i_step_count (i_step_count),
        .i_drv_valid  (o_valid),
        .i_drv_stall  (i_stall),
        .i_drive      (drive_seen),
        .o_mismatches (mismatches),
        .o_outstanding(outstanding),
        .o_compared   (compared)
    );

    always @(posedge i_clk) begin
        cycles  <= cycles + 1;
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic send_item(input logic [3:0] op, input logic [SCW-1:0] cnt);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_opcode     <= op;
        i_step_count <= cnt;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sent++;
    endtask

    initial begin
        wait (cycles == CYCLE_LIMIT);
        $display("lens_and_pan_tilt_stepper_sequencer_core regression: fail");
        $finish;
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // idle tick, single step from a zero count, lens direction reversal
        send_item(OP_TICK, 16'hFFFF);
        send_item(OP_FOCUS_MINUS, 16'd0);
        send_item(OP_TICK, 16'd0);
        send_item(OP_FOCUS_PLUS, 16'd2);
        send_item(OP_TICK, 16'd0);
        send_item(OP_TICK, 16'd0);
        // standby, then lens moves with the catch-up step
        send_item(OP_STANDBY, 16'd0);
        send_item(OP_ZOOM_UP, 16'd1);
        send_item(OP_FOCUS_MINUS, 16'd3);
        send_item(OP_TICK, 16'd0);
        send_item(OP_TICK, 16'd0);
        send_item(OP_TICK, 16'd0);
        send_item(OP_TICK, 16'd0);
        send_item(OP_TICK, 16'd0);
        // pan priority over tilt, move replacing a running one
        send_item(OP_PAN_LEFT, 16'hFFFF);
        send_item(OP_TILT_DOWN, 16'd0);
        send_item(OP_TICK, 16'd0);
        send_item(OP_TICK, 16'd0);
        send_item(OP_PAN_RIGHT, 16'd1);
        send_item(OP_TICK, 16'd0);
        send_item(OP_TICK, 16'd0);
        send_item(OP_TILT_UP, 16'd2);
        send_item(OP_ZOOM_DOWN, 16'd0);
        send_item(OP_UNUSED_LO, 16'h5A5A);
        send_item(OP_UNUSED_HI, 16'hA5A5);
        send_item(OP_TICK, 16'd0);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            idle_pct  = (n >= 600 && n < 900) ? 0 : 31;
            stall_pct = idle_pct;
            pick = $urandom_range(99);
            if (pick < 48) begin
                r_op = OP_TICK;
            end else if (pick < 88) begin
                r_op = 4'($urandom_range(OP_TILT_DOWN, OP_FOCUS_MINUS));
            end else if (pick < 93) begin
                r_op = OP_STANDBY;
            end else begin
                r_op = 4'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
            end
            // mostly short moves so that zoom and tilt get their turn
            pick = $urandom_range(99);
            if (pick < 75) begin
                r_cnt = SCW'($urandom_range(5));
            end else if (pick < 95) begin
                r_cnt = SCW'($urandom_range(300));
            end else begin
                r_cnt = SCW'($urandom);
            end
            send_item(r_op, r_cnt);
        end
        i_valid <= 1'b0;

        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        $display("%0d commands and ticks sent, incl. standby, unused codes and long moves",
                 sent);
        $display("%0d coil drive transfers compared, %0d mismatching fields",
                 compared, mismatches);
        if (mismatches == 0) begin
            $display("lens_and_pan_tilt_stepper_sequencer_core regression: pass");
        end else begin
            $display("lens_and_pan_tilt_stepper_sequencer_core regression: fail");
        end
        $finish;
    end

endmodule

@@ lens_and_pan_tilt_stepper_sequencer_core.f @@
src/ltss_pkg.sv
src/lens_and_pan_tilt_stepper_sequencer_core.sv
bench/ltss_drive_checker.sv
bench/testbench.sv
